// ----- sv/qre_pkg.sv -----
// ----------------------------------------------------------------------------
// qre_pkg
// shared types and constants of the 2x2 qr eigenvalue block
// ----------------------------------------------------------------------------
package qre_pkg;

  localparam int unsigned WordWidthDef = 32;
  localparam int unsigned FracBitsDef  = 24;
  localparam int unsigned FieldWidth   = 32;
  localparam int unsigned TolWidth     = 31;
  localparam int unsigned LimitWidth   = 8;
  localparam int unsigned CfgWidth     = 31;
  localparam int unsigned CfgIdxWidth  = 1;

  localparam logic [CfgIdxWidth-1:0] RegTolerance = 1'b0;
  localparam logic [CfgIdxWidth-1:0] RegLimit     = 1'b1;

  typedef enum logic [1:0] {
    StatConverged = 2'd0,
    StatLimit     = 2'd1,
    StatZeroCol   = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [FieldWidth-1:0] top_left;
    logic signed [FieldWidth-1:0] top_right;
    logic signed [FieldWidth-1:0] bottom_left;
    logic signed [FieldWidth-1:0] bottom_right;
  } in_item_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] first_eigen;
    logic signed [FieldWidth-1:0] second_eigen;
    logic [1:0]                   status;
    logic [LimitWidth-1:0]        iterations_used;
  } out_item_t;

  // sequencer states
  typedef enum logic [3:0] {
    StIdle,
    StCheck,
    StSqMul,
    StSqrt,
    StDivInit,
    StDiv,
    StDivDone,
    StMul,
    StMulDone,
    StCombine,
    StTest,
    StDone
  } state_e;

endpackage

// ----- sv/qr_eigenvalue_2x2.sv -----
// ----------------------------------------------------------------------------
// qr_eigenvalue_2x2
// unshifted qr iteration on one 2x2 fixed point matrix per item
// ----------------------------------------------------------------------------
// One item is a real 2x2 matrix in signed fixed point; the result item gives
// the diagonal after unshifted QR iterations, a status and the iteration
// count. All arithmetic runs on one shared datapath under a sequencer: each
// iteration spends a check state, the squares, a bit-serial square root,
// two restoring divisions, ten products on the one registered multiplier
// (each issued in StMul and taken in StMulDone), a combine state and the
// test state for the two lower-row products and the convergence test. The
// input is stalled from acceptance until the result is moved to the output
// register; a result may wait there while the next item is running.
module qr_eigenvalue_2x2
  import qre_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = WordWidthDef,
  parameter int unsigned FRAC_BITS  = FracBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_item_t               in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_item_o
);

  localparam int unsigned W   = WORD_WIDTH;
  localparam int unsigned PW  = 2 * W;           // product / square width
  localparam int unsigned SW  = PW + 1;          // sum of two squares
  localparam int unsigned NW  = W + 1;           // norm width (sqrt of SW)
  localparam int unsigned DNW = W + FRAC_BITS + 1; // dividend width
  localparam int unsigned CW  = $clog2(DNW + 1);
  localparam logic signed [W-1:0] WMax = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMin = {1'b1, {(W-1){1'b0}}};

  // saturate a signed value of up to PW+2 bits to the word
  function automatic logic signed [W-1:0] sat_w(input logic signed [PW+1:0] v);
    if (v > $signed({{(PW+2-W){1'b0}}, WMax})) return WMax;
    if (v < $signed({{(PW+2-W){1'b1}}, WMin})) return WMin;
    return v[W-1:0];
  endfunction

  // registers
  logic [TolWidth-1:0]   tol_q;
  logic [LimitWidth-1:0] lim_q;

  state_e state_q, state_d;
  logic signed [W-1:0] a00_q, a01_q, a10_q, a11_q, a00_d, a01_d, a10_d, a11_d;
  logic signed [W-1:0] c_q, s_q, c_d, s_d;
  logic signed [W-1:0] r00_q, r01_q, r11_q, r00_d, r01_d, r11_d;
  logic signed [W-1:0] p_q [10];
  logic signed [W-1:0] p_d;
  logic [SW-1:0]  sum_q, sum_d;
  logic [NW-1:0]  root_q, root_d;
  logic [SW-1:0]  rrem_q, rrem_d;
  logic [DNW-1:0] dnum_q, dnum_d;
  logic [NW:0]    drem_q, drem_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [3:0]     step_q, step_d;
  logic           dsel_q, dsel_d;
  logic [LimitWidth-1:0] used_q, used_d;
  logic [1:0]     stat_q, stat_d;
  logic           ovalid_q, ovalid_d;
  out_item_t      res_q, res_d;
  logic signed [PW-1:0] mprod_q;
  logic signed [W-1:0]  mx, my;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolWidth'(16);
      lim_q <= LimitWidth'(100);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTolerance: tol_q <= cfg_data_i[TolWidth-1:0];
        RegLimit:     lim_q <= cfg_data_i[LimitWidth-1:0];
        default:      ;
      endcase
    end
  end

  // input saturation to the word
  function automatic logic signed [W-1:0] from_field(input logic signed [FieldWidth-1:0] f);
    logic signed [PW+1:0] e;
    e = (PW+2)'(f);
    return sat_w(e);
  endfunction

  // shared multiplier operand select
  always_comb begin
    mx = c_q;
    my = a00_q;
    case (state_q)
      StSqMul: begin
        mx = (step_q == 4'd0) ? a00_q : a10_q;
        my = mx;
      end
      default: begin
        case (step_q)
          4'd0: begin mx = c_q;   my = a00_q; end
          4'd1: begin mx = s_q;   my = a10_q; end
          4'd2: begin mx = c_q;   my = a01_q; end
          4'd3: begin mx = s_q;   my = a11_q; end
          4'd4: begin mx = c_q;   my = a11_q; end
          4'd5: begin mx = s_q;   my = a01_q; end
          4'd6: begin mx = r00_q; my = c_q;   end
          4'd7: begin mx = r01_q; my = s_q;   end
          4'd8: begin mx = r01_q; my = c_q;   end
          4'd10: begin mx = r11_q; my = s_q;  end
          4'd11: begin mx = r11_q; my = s_q;  end
          4'd12: begin mx = r11_q; my = c_q;  end
          default: begin mx = r00_q; my = s_q; end
        endcase
      end
    endcase
  end

  // registered multiplier
  always_ff @(posedge clk_i) begin
    mprod_q <= mx * my;
  end

  // rounding of the registered product, half away from zero
  always_comb begin
    logic [PW-1:0] m;
    logic [PW:0]   r;
    logic signed [PW+1:0] v;
    m = mprod_q[PW-1] ? PW'(-mprod_q) : PW'(mprod_q);
    r = ({1'b0, m} + ((PW+1)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
    v = mprod_q[PW-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    p_d = sat_w(v);
  end

  logic [W-1:0] mag00, mag10;
  assign mag00 = a00_q[W-1] ? W'(-a00_q) : W'(a00_q);
  assign mag10 = a10_q[W-1] ? W'(-a10_q) : W'(a10_q);

  // sequencer
  always_comb begin
    logic [SW-1:0] trial;
    logic [SW-1:0] rem2;
    logic [NW:0]   dr;
    logic signed [W+1:0] q;
    logic [W-1:0]  n10m;
    state_d = state_q;
    a00_d = a00_q; a01_d = a01_q; a10_d = a10_q; a11_d = a11_q;
    c_d = c_q; s_d = s_q; r00_d = r00_q; r01_d = r01_q; r11_d = r11_q;
    sum_d = sum_q; root_d = root_q; rrem_d = rrem_q;
    dnum_d = dnum_q; drem_d = drem_q; cnt_d = cnt_q; step_d = step_q;
    dsel_d = dsel_q; used_d = used_q; stat_d = stat_q; ovalid_d = ovalid_q;
    res_d = res_q;
    trial = '0; rem2 = '0; dr = '0; q = '0; n10m = '0;
    // result item leaves the output register
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          a00_d = from_field(in_item_i.top_left);
          a01_d = from_field(in_item_i.top_right);
          a10_d = from_field(in_item_i.bottom_left);
          a11_d = from_field(in_item_i.bottom_right);
          used_d = '0;
          state_d = StCheck;
        end
      end
      StCheck: begin
        step_d = '0;
        if (used_q >= lim_q) begin
          stat_d = StatLimit; state_d = StDone;
        end else if (a00_q == '0 && a10_q == '0) begin
          stat_d = StatZeroCol; state_d = StDone;
        end else begin
          state_d = StSqMul;
        end
      end
      StSqMul: begin
        // step 0 issue a00^2, step 1 issue a10^2 and take a00^2, step 2 take a10^2
        if (step_q == 4'd1) sum_d = SW'($unsigned(mprod_q));
        if (step_q == 4'd2) begin
          sum_d = sum_q + SW'($unsigned(mprod_q));
          root_d = '0; rrem_d = '0; cnt_d = CW'(NW);
          state_d = StSqrt;
        end
        step_d = step_q + 4'd1;
      end
      StSqrt: begin
        // restoring square root, two radicand bits a cycle (the odd top bit alone)
        rem2 = {rrem_q[SW-3:0], sum_q[SW-1 -: 2]};
        if (SW % 2 == 1 && cnt_q == CW'(NW)) rem2 = {{(SW-1){1'b0}}, sum_q[SW-1]};
        trial = {root_q[NW-2:0], 2'b01};
        if (rem2 >= trial) begin
          rrem_d = rem2 - trial; root_d = {root_q[NW-2:0], 1'b1};
        end else begin
          rrem_d = rem2; root_d = {root_q[NW-2:0], 1'b0};
        end
        sum_d = (SW % 2 == 1 && cnt_q == CW'(NW)) ? {sum_q[SW-2:0], 1'b0} :
                {sum_q[SW-3:0], 2'b00};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          dsel_d = 1'b0; state_d = StDivInit;
        end
      end
      StDivInit: begin
        dnum_d = ({{(FRAC_BITS+1){1'b0}}, dsel_q ? mag10 : mag00} << FRAC_BITS)
                 + DNW'(root_q >> 1);
        drem_d = '0; cnt_d = CW'(DNW);
        state_d = StDiv;
      end
      StDiv: begin
        // restoring division, one quotient bit a cycle
        dr = {drem_q[NW-1:0], dnum_q[DNW-1]};
        if (dr >= {1'b0, root_q}) begin
          drem_d = dr - {1'b0, root_q}; dnum_d = {dnum_q[DNW-2:0], 1'b1};
        end else begin
          drem_d = dr; dnum_d = {dnum_q[DNW-2:0], 1'b0};
        end
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) state_d = StDivDone;
      end
      StDivDone: begin
        q = (dnum_q > DNW'(WMax)) ? ((W+2)'(1) << (W-1)) : (W+2)'(dnum_q);
        q = (dsel_q ? a10_q[W-1] : a00_q[W-1]) ? -q : q;
        if (!dsel_q) begin
          c_d = sat_w((PW+2)'(q));
          dsel_d = 1'b1; state_d = StDivInit;
        end else begin
          s_d = sat_w((PW+2)'(q));
          step_d = '0; state_d = StMul;
        end
      end
      StMul: begin
        state_d = StMulDone;
      end
      StMulDone: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'd5) begin
          r00_d = sat_w((PW+2)'(p_q[0]) + (PW+2)'(p_q[1]));
          r01_d = sat_w((PW+2)'(p_q[2]) + (PW+2)'(p_q[3]));
          r11_d = sat_w((PW+2)'(p_q[4]) - (PW+2)'(p_d));
        end
        state_d = (step_q == 4'd9) ? StCombine : StMul;
      end
      StCombine: begin
        a00_d = sat_w((PW+2)'(p_q[6]) + (PW+2)'(p_q[7]));
        a01_d = sat_w((PW+2)'(p_q[8]) - (PW+2)'(p_q[9]));
        step_d = 4'd10;
        state_d = StTest;
      end
      StTest: begin
        // new lower-left and lower-right from r11 with s and c (two products)
        if (step_q == 4'd10) begin
          step_d = 4'd11;
        end else if (step_q == 4'd11) begin
          step_d = 4'd12;
        end else if (step_q == 4'd12) begin
          a10_d = p_d; step_d = 4'd13;
        end else begin
          a11_d = p_d;
          used_d = used_q + LimitWidth'(1);
          n10m = a10_q[W-1] ? W'(-a10_q) : W'(a10_q);
          if ((W+TolWidth)'(n10m) < (W+TolWidth)'(tol_q)) begin
            stat_d = StatConverged; state_d = StDone;
          end else begin
            state_d = StCheck;
          end
        end
      end
      StDone: begin
        // move the result into the output register once it is free
        if (!ovalid_q || !out_stall_i) begin
          res_d.first_eigen     = FieldWidth'(a00_q);
          res_d.second_eigen    = FieldWidth'(a11_q);
          res_d.status          = stat_q;
          res_d.iterations_used = used_q;
          ovalid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
      step_q   <= '0;
      cnt_q    <= '0;
      dsel_q   <= 1'b0;
      used_q   <= '0;
      stat_q   <= StatLimit;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      step_q   <= step_d;
      cnt_q    <= cnt_d;
      dsel_q   <= dsel_d;
      used_q   <= used_d;
      stat_q   <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a00_q <= a00_d; a01_q <= a01_d; a10_q <= a10_d; a11_q <= a11_d;
    c_q <= c_d; s_q <= s_d;
    r00_q <= r00_d; r01_q <= r01_d; r11_q <= r11_d;
    sum_q <= sum_d; root_q <= root_d; rrem_q <= rrem_d;
    dnum_q <= dnum_d; drem_q <= drem_d;
    res_q <= res_d;
    if (state_q == StMulDone) p_q[step_q] <= p_d;
  end

  // outputs
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = ovalid_q;
  assign out_item_o  = res_q;

  // checks
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.status <= StatZeroCol) else $error("bad status code");
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.iterations_used <= lim_q)
    else $error("iteration count over limit");

endmodule
